@@ rtl/ilem_pkg.sv @@
// -----------------------------------------------------------------------------
// ilem_pkg
// Types, codes and helpers for the spin lattice energy and magnetization block.
// -----------------------------------------------------------------------------
package ilem_pkg;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 6;
    localparam int ENERGY_W = 15;
    localparam int MAG_W    = 13;
    localparam int COST_W   = 5;

    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOTALS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP   = 2'd2;

    localparam logic KIND_TOTALS = 1'b0;
    localparam logic KIND_FLIP   = 1'b1;

    localparam int ENERGY_MAX = 16383;
    localparam int ENERGY_MIN = -16384;
    localparam int MAG_MAX    = 8191;

    // center, right, down, left, up
    localparam logic [2:0] FLIP_READS = 3'd5;
    localparam logic [2:0] STEP_C     = 3'd0;
    localparam logic [2:0] STEP_R     = 3'd1;
    localparam logic [2:0] STEP_D     = 3'd2;
    localparam logic [2:0] STEP_L     = 3'd3;
    localparam logic [2:0] STEP_U     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FLIP   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // bond term -a*b for +1/-1 spins: +1 when they differ, -1 when equal
    function automatic logic signed [3:0] bond(input logic en, input logic a,
                                               input logic b);
        logic signed [3:0] v;
        v = (a ^ b) ? 4'sd1 : -4'sd1;
        return en ? v : 4'sd0;
    endfunction

endpackage

@@ rtl/ising_lattice_energy_magnetization_top.sv @@
// -----------------------------------------------------------------------------
// ising_lattice_energy_magnetization_top
// Toroidal spin lattice: spin write, total bond energy and |magnetization|,
// and single-site flip cost; every read goes through one read port of the spin memory.
// -----------------------------------------------------------------------------
//  channel   handshake               payload
//  command   start / busy            i_mode, i_row, i_col, i_spin_up
//  result    o_valid (1-cycle pulse) o_answer_kind, o_energy_sum,
//                                    o_magnetization_abs, o_flip_cost
//
//  write: fold row/col into range by subtracting SIDE, then write the spin
//  flip cost: fold as for a write, then 5 memory reads
//  totals: one memory read per site over the whole lattice
//  flip cost and totals share the single registered read port of the spin memory
//  synchronous active-low reset clears control only; the spin memory is not cleared
//  the result strobe cannot be held off by the receiver
// -----------------------------------------------------------------------------
module ising_lattice_energy_magnetization_top
    import ilem_pkg::*;
#(
    parameter int SIDE = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [IDX_W-1:0]           i_row,
    input  logic [IDX_W-1:0]           i_col,
    input  logic                       i_spin_up,
    output logic                       o_valid,
    output logic                       o_answer_kind,
    output logic signed [ENERGY_W-1:0] o_energy_sum,
    output logic [MAG_W-1:0]           o_magnetization_abs,
    output logic signed [COST_W-1:0]   o_flip_cost
);

    localparam int RW    = $clog2(SIDE);
    localparam int AW    = 2 * RW;
    localparam int DEPTH = 2 ** AW;
    localparam int XW    = (RW + 1 > IDX_W) ? RW + 1 : IDX_W;
    localparam int EW    = (2 * RW + 3 > 16) ? 2 * RW + 3 : 16;
    localparam int MW    = (2 * RW + 2 > 15) ? 2 * RW + 2 : 15;

    localparam logic [RW-1:0]        LAST_IDX = RW'(SIDE - 1);
    localparam logic [XW-1:0]        SIDE_X   = XW'(SIDE);
    localparam logic signed [EW-1:0] E_HI     = EW'(ENERGY_MAX);
    localparam logic signed [EW-1:0] E_LO     = EW'(ENERGY_MIN);
    localparam logic [MW-1:0]        M_HI     = MW'(MAG_MAX);

    t_state r_state, n_state;

    logic [MODE_W-1:0] r_mode;
    logic [XW-1:0]     r_row, r_col;
    logic              r_spin;

    // spin memory
    logic              r_mem [0:DEPTH-1];
    logic              r_rdata;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;

    // scan issue and data side
    logic              r_issue;
    logic [RW-1:0]     r_srow, r_scol;
    logic              r_dvalid;
    logic [RW-1:0]     r_drow, r_dcol;
    logic [SIDE-1:0]   r_line;
    logic [SIDE-1:0]   r_first;
    logic              r_rowfirst;
    logic signed [EW-1:0] r_energy;
    logic signed [MW-1:0] r_mag;

    // flip sequencing
    logic [2:0]        r_step, r_dstep;
    logic              r_center;
    logic [2:0]        r_ups;

    logic [RW-1:0]     rr, cc, rp1, rm1, cp1, cm1;
    logic              in_range;
    logic              scan_last;
    logic signed [3:0] delta;
    logic [2:0]        ups_fin;
    logic signed [5:0] cost_pos;
    logic signed [5:0] cost;
    logic [MW-1:0]     mag_abs;

    assign busy = (r_state != S_IDLE);

    assign rr  = r_row[RW-1:0];
    assign cc  = r_col[RW-1:0];
    assign rp1 = (rr == LAST_IDX) ? '0 : rr + RW'(1);
    assign rm1 = (rr == '0) ? LAST_IDX : rr - RW'(1);
    assign cp1 = (cc == LAST_IDX) ? '0 : cc + RW'(1);
    assign cm1 = (cc == '0) ? LAST_IDX : cc - RW'(1);

    assign in_range = (r_row < SIDE_X) && (r_col < SIDE_X);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {r_srow, r_scol};
        if (r_state == S_SCAN) begin
            rd_en = r_issue;
        end else if (r_state == S_FLIP) begin
            rd_en = (r_step < FLIP_READS);
            case (r_step)
                STEP_C:  rd_addr = {rr, cc};
                STEP_R:  rd_addr = {rr, cp1};
                STEP_D:  rd_addr = {rp1, cc};
                STEP_L:  rd_addr = {rr, cm1};
                default: rd_addr = {rm1, cc};
            endcase
        end
    end

    assign wr_en   = (r_state == S_REDUCE) && in_range && (r_mode == MODE_WRITE);
    assign wr_addr = {rr, cc};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_spin;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // per-site energy change: left and up bonds, plus the wrap bonds on the last col/row
    assign delta = bond(r_dcol != '0, r_rdata, r_line[0])
                 + bond(r_drow != '0, r_rdata, r_line[SIDE-1])
                 + bond(r_dcol == LAST_IDX, r_rdata, r_rowfirst)
                 + bond(r_drow == LAST_IDX, r_rdata, r_first[SIDE-1]);

    assign scan_last = r_dvalid && (r_drow == LAST_IDX) && (r_dcol == LAST_IDX);

    assign ups_fin  = r_ups + {2'b00, r_rdata};
    assign cost_pos = $signed({1'b0, ups_fin, 2'b00}) - 6'sd8;
    assign cost     = r_center ? cost_pos : -cost_pos;

    assign mag_abs = r_mag[MW-1] ? MW'(-r_mag) : MW'(r_mag);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_mode == MODE_TOTALS) begin
                        n_state = S_SCAN;
                    end else if (i_mode == MODE_WRITE || i_mode == MODE_FLIP) begin
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (in_range) begin
                    n_state = (r_mode == MODE_FLIP) ? S_FLIP : S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FLIP: begin
                if (r_dvalid && r_dstep == STEP_U) begin
                    n_state = S_IDLE;
                end
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issue  <= 1'b0;
            r_dvalid <= 1'b0;
            r_step   <= FLIP_READS;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dvalid <= rd_en;
            o_valid  <= (r_state == S_FINISH) ||
                        (r_state == S_FLIP && r_dvalid && r_dstep == STEP_U);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_issue <= (i_mode == MODE_TOTALS);
                    end
                end
                S_REDUCE: begin
                    if (in_range && r_mode == MODE_FLIP) begin
                        r_step <= STEP_C;
                    end
                end
                S_SCAN: begin
                    if (r_issue && r_srow == LAST_IDX && r_scol == LAST_IDX) begin
                        r_issue <= 1'b0;
                    end
                end
                S_FLIP: begin
                    if (r_step < FLIP_READS) begin
                        r_step <= r_step + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_dstep <= r_step;
        r_drow  <= r_srow;
        r_dcol  <= r_scol;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_mode   <= i_mode;
                    r_row    <= XW'(i_row);
                    r_col    <= XW'(i_col);
                    r_spin   <= i_spin_up;
                    r_srow   <= '0;
                    r_scol   <= '0;
                    r_energy <= '0;
                    r_mag    <= '0;
                end
            end
            S_REDUCE: begin
                // fold indices into the lattice one subtraction per cycle
                if (r_row >= SIDE_X) begin
                    r_row <= r_row - SIDE_X;
                end
                if (r_col >= SIDE_X) begin
                    r_col <= r_col - SIDE_X;
                end
                r_ups <= '0;
            end
            S_SCAN: begin
                if (r_issue) begin
                    if (r_scol == LAST_IDX) begin
                        r_scol <= '0;
                        r_srow <= r_srow + RW'(1);
                    end else begin
                        r_scol <= r_scol + RW'(1);
                    end
                end
                if (r_dvalid) begin
                    r_energy <= r_energy + EW'(delta);
                    r_mag    <= r_rdata ? r_mag + MW'(1) : r_mag - MW'(1);
                    r_line   <= {r_line[SIDE-2:0], r_rdata};
                    if (r_dcol == '0) begin
                        r_rowfirst <= r_rdata;
                    end
                    // top row is kept, then rotated out against the bottom row
                    if (r_drow == '0) begin
                        r_first <= {r_first[SIDE-2:0], r_rdata};
                    end else if (r_drow == LAST_IDX) begin
                        r_first <= {r_first[SIDE-2:0], r_first[SIDE-1]};
                    end
                end
            end
            S_FLIP: begin
                if (r_dvalid) begin
                    if (r_dstep == STEP_C) begin
                        r_center <= r_rdata;
                    end else begin
                        r_ups <= ups_fin;
                    end
                    if (r_dstep == STEP_U) begin
                        o_answer_kind       <= KIND_FLIP;
                        o_energy_sum        <= '0;
                        o_magnetization_abs <= '0;
                        o_flip_cost         <= cost[COST_W-1:0];
                    end
                end
            end
            S_FINISH: begin
                o_answer_kind <= KIND_TOTALS;
                o_flip_cost   <= '0;
                if (r_energy > E_HI) begin
                    o_energy_sum <= E_HI[ENERGY_W-1:0];
                end else if (r_energy < E_LO) begin
                    o_energy_sum <= E_LO[ENERGY_W-1:0];
                end else begin
                    o_energy_sum <= r_energy[ENERGY_W-1:0];
                end
                o_magnetization_abs <= (mag_abs > M_HI) ? M_HI[MAG_W-1:0]
                                                        : mag_abs[MAG_W-1:0];
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_FINISH || $past(r_state) == S_FLIP))
        else $error("result strobe outside finish or flip");

    a_totals_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_TOTALS) |=> (r_state == S_SCAN && r_issue))
        else $error("totals command did not start the scan");

    a_flip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_answer_kind == KIND_FLIP) |->
            (o_energy_sum == '0 && o_magnetization_abs == '0))
        else $error("flip result carries totals");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_dvalid)
        else $error("read data pending while idle");
`endif

endmodule
